// ===== src/broadcast_operand_address_gen_assert.svh =====
// ----------------------------------------------------------------------------
// Broadcast operand address generator assertion macros
// Concurrent checks on clk, disabled during rst; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_OPERAND_ADDRESS_GEN_ASSERT_SVH
`define BROADCAST_OPERAND_ADDRESS_GEN_ASSERT_SVH

`ifndef SYNTH
`define BOAG_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define BOAG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BOAG_ASSERT(label, cond)
`define BOAG_ASSERT_IMP(label, ante, cons)
`endif

`endif

// ===== src/boag_pkg.sv =====
// ----------------------------------------------------------------------------
// boag_pkg
// Shared widths, defaults and register indexes of the address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package boag_pkg;

  localparam int FLAT_W       = 32;
  localparam int OFS_W        = 42;
  localparam int STRIDE_W     = 32;
  localparam int DIMS_W       = 32;
  localparam int STRIDES_W    = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int DIV_STEPS    = 4;
  localparam int STRIDE_DIMS  = 4;
  localparam int MAX_RANK_DEF = 4;
  localparam int DIM_BITS_DEF = 8;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 32'h0101_0101;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_DIMS          = 3'd0,
    CFG_B_DIMS          = 3'd1,
    CFG_A_STRIDES_OUTER = 3'd2,
    CFG_A_STRIDES_INNER = 3'd3,
    CFG_B_STRIDES_OUTER = 3'd4,
    CFG_B_STRIDES_INNER = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/broadcast_operand_address_gen.sv =====
// ----------------------------------------------------------------------------
// Broadcast operand address generator
// Splits a flat result index into broadcast coordinates and forms the
// storage offsets of both operands.
// ----------------------------------------------------------------------------
// Input channel: flat_index with in_valid / in_stall; a transaction completes
// when in_valid is high and in_stall low. Output channel: offset_a, offset_b,
// in_range, shape_error, result_count with out_valid / out_stall.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no transaction is in flight.
// Each dimension runs a restoring divider retiring DIV_STEPS quotient bits per
// stage, then a stage of stride multipliers and the element count product.
// Throughput: one transaction per cycle while out_stall does not hold the pipeline.
// Reset clears all valid bits and sets every size to 1 and every stride to 0.
// While out_valid is high and out_stall is asserted the whole pipeline holds
// and in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_operand_address_gen #(
  parameter int MAX_RANK = boag_pkg::MAX_RANK_DEF,
  parameter int DIM_BITS = boag_pkg::DIM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [boag_pkg::FLAT_W-1:0]    flat_index,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [boag_pkg::OFS_W-1:0]          offset_a,
  output logic [boag_pkg::OFS_W-1:0]          offset_b,
  output logic                                in_range,
  output logic                                shape_error,
  output logic [boag_pkg::FLAT_W-1:0]         result_count,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [boag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [boag_pkg::STRIDES_W-1:0] cfg_data
);

  import boag_pkg::*;

`include "broadcast_operand_address_gen_assert.svh"

  localparam int CW    = DIM_BITS;
  localparam int DSTG  = FLAT_W / DIV_STEPS;
  localparam int GSTG  = DSTG + 1;
  localparam int P     = MAX_RANK * GSTG + 1;
  localparam int MW    = (STRIDE_W + CW > OFS_W) ? STRIDE_W + CW : OFS_W;
  localparam int CMW   = FLAT_W + CW;

  logic [DIMS_W-1:0]    a_dims, b_dims;
  logic [STRIDES_W-1:0] a_strides_outer, a_strides_inner;
  logic [STRIDES_W-1:0] b_strides_outer, b_strides_inner;

  function automatic logic [CW-1:0] dim_size(input logic [DIMS_W-1:0] dims, input int d);
    int                sh;
    logic [DIMS_W-1:0] v;
    sh = (MAX_RANK - 1 - d) * DIM_BITS;
    v  = dims >> sh;
    if (sh >= DIMS_W) begin
      return CW'(1);
    end
    return v[CW-1:0];
  endfunction

  function automatic logic [STRIDE_W-1:0] stride_of(input logic [STRIDES_W-1:0] outer,
                                                    input logic [STRIDES_W-1:0] inner,
                                                    input int d);
    case (d)
      0:       return outer[2*STRIDE_W-1:STRIDE_W];
      1:       return outer[STRIDE_W-1:0];
      2:       return inner[2*STRIDE_W-1:STRIDE_W];
      3:       return inner[STRIDE_W-1:0];
      default: return '0;
    endcase
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_dims          <= DIMS_RESET;
      b_dims          <= DIMS_RESET;
      a_strides_outer <= '0;
      a_strides_inner <= '0;
      b_strides_outer <= '0;
      b_strides_inner <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_A_DIMS:          a_dims          <= cfg_data[DIMS_W-1:0];
        CFG_B_DIMS:          b_dims          <= cfg_data[DIMS_W-1:0];
        CFG_A_STRIDES_OUTER: a_strides_outer <= cfg_data;
        CFG_A_STRIDES_INNER: a_strides_inner <= cfg_data;
        CFG_B_STRIDES_OUTER: b_strides_outer <= cfg_data;
        CFG_B_STRIDES_INNER: b_strides_inner <= cfg_data;
        default: ;
      endcase
    end
  end

  logic err;

  always_comb begin
    logic [CW-1:0] sa, sb;
    err = 1'b0;
    for (int d = 0; d < MAX_RANK; d++) begin
      sa = dim_size(a_dims, d);
      sb = dim_size(b_dims, d);
      if (sa == '0 || sb == '0) begin
        err = 1'b1;
      end
      if (sa != sb && sa != CW'(1) && sb != CW'(1)) begin
        err = 1'b1;
      end
    end
  end

  logic              vld   [P+1];
  logic [FLAT_W-1:0] flat  [P];
  logic [FLAT_W-1:0] quo   [P];
  logic [CW:0]       rem   [P];
  logic [OFS_W-1:0]  acc_a [P];
  logic [OFS_W-1:0]  acc_b [P];
  logic [OFS_W-1:0]  pa    [P];
  logic [OFS_W-1:0]  pb    [P];
  logic [FLAT_W-1:0] cnt   [P];
  logic              big   [P];

  logic advance;

  assign advance   = !vld[P] || !out_stall;
  assign in_stall  = !advance;
  assign out_valid = vld[P];

  assign vld[0]   = in_valid;
  assign flat[0]  = flat_index;
  assign quo[0]   = flat_index;
  assign rem[0]   = '0;
  assign acc_a[0] = '0;
  assign acc_b[0] = '0;
  assign pa[0]    = '0;
  assign pb[0]    = '0;
  assign cnt[0]   = FLAT_W'(1);
  assign big[0]   = 1'b0;

  for (genvar k = 1; k <= P; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_stage
    localparam int G = (k - 1) / GSTG;
    localparam int S = (k - 1) % GSTG;
    localparam int D = MAX_RANK - 1 - G;

    logic [FLAT_W-1:0] quo_next;
    logic [CW:0]       rem_next;
    logic [OFS_W-1:0]  acc_a_next, acc_b_next, pa_next, pb_next;
    logic [FLAT_W-1:0] cnt_next;
    logic              big_next;

    always_comb begin
      logic [CW-1:0]    asz, bsz, rsz;
      logic [CW:0]      sh;
      logic             ge;
      logic [MW-1:0]    ma, mb;
      logic [CMW-1:0]   cm;
      asz        = dim_size(a_dims, D);
      bsz        = dim_size(b_dims, D);
      rsz        = (asz > bsz) ? asz : bsz;
      quo_next   = quo[k-1];
      rem_next   = (S == 0) ? '0 : rem[k-1];
      acc_a_next = acc_a[k-1];
      acc_b_next = acc_b[k-1];
      pa_next    = pa[k-1];
      pb_next    = pb[k-1];
      cnt_next   = cnt[k-1];
      big_next   = big[k-1];
      ma         = '0;
      mb         = '0;
      cm         = '0;
      if (S < DSTG) begin
        acc_a_next = acc_a[k-1] + pa[k-1];
        acc_b_next = acc_b[k-1] + pb[k-1];
        pa_next    = '0;
        pb_next    = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
          sh       = {rem_next[CW-1:0], quo_next[FLAT_W-1]};
          ge       = (sh >= {1'b0, rsz});
          quo_next = {quo_next[FLAT_W-2:0], ge};
          rem_next = ge ? (sh - {1'b0, rsz}) : sh;
        end
      end else begin
        if (asz != CW'(1)) begin
          ma = MW'(stride_of(a_strides_outer, a_strides_inner, D)) * MW'(rem[k-1][CW-1:0]);
        end
        if (bsz != CW'(1)) begin
          mb = MW'(stride_of(b_strides_outer, b_strides_inner, D)) * MW'(rem[k-1][CW-1:0]);
        end
        pa_next  = ma[OFS_W-1:0];
        pb_next  = mb[OFS_W-1:0];
        cm       = CMW'(cnt[k-1]) * CMW'(rsz);
        big_next = big[k-1] || (|cm[CMW-1:FLAT_W]);
        cnt_next = big_next ? '1 : cm[FLAT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        flat[k]  <= flat[k-1];
        quo[k]   <= quo_next;
        rem[k]   <= rem_next;
        acc_a[k] <= acc_a_next;
        acc_b[k] <= acc_b_next;
        pa[k]    <= pa_next;
        pb[k]    <= pb_next;
        cnt[k]   <= cnt_next;
        big[k]   <= big_next;
      end
    end
  end

  logic [OFS_W-1:0] sum_a, sum_b;
  logic             inr;

  assign sum_a = acc_a[P-1] + pa[P-1];
  assign sum_b = acc_b[P-1] + pb[P-1];
  assign inr   = big[P-1] || (flat[P-1] < cnt[P-1]);

  always_ff @(posedge clk) begin
    if (advance) begin
      offset_a     <= (err || !inr) ? '0 : sum_a;
      offset_b     <= (err || !inr) ? '0 : sum_b;
      in_range     <= !err && inr;
      shape_error  <= err;
      result_count <= err ? '0 : cnt[P-1];
    end
  end

  `BOAG_ASSERT_IMP(a_err_zero, out_valid && shape_error,
    offset_a == '0 && offset_b == '0 && !in_range && result_count == '0)
  `BOAG_ASSERT_IMP(a_oor_zero, out_valid && !in_range, offset_a == '0 && offset_b == '0)
  `BOAG_ASSERT_IMP(a_count_nz, out_valid && !shape_error, result_count != '0)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Broadcast operand address generator testbench
// Drives flat indexes under several shape and stride settings, predicts the
// operand offsets, range flag, shape error and element count of each one,
// and compares every output transaction in order. Both channels idle and
// stall at random; a directed table opens each run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import boag_pkg::*;

  localparam int RANK       = MAX_RANK_DEF;
  localparam int DBITS      = DIM_BITS_DEF;
  localparam int LATENCY    = 37;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OFS_W-1:0]  ofs_a;
    logic [OFS_W-1:0]  ofs_b;
    logic              inr;
    logic              serr;
    logic [FLAT_W-1:0] cnt;
  } addr_result_t;

  typedef struct {
    logic [FLAT_W-1:0] idx;
    bit                known;
    addr_result_t      res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FLAT_W-1:0]    flat_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OFS_W-1:0]     offset_a;
  logic [OFS_W-1:0]     offset_b;
  logic                 in_range;
  logic                 shape_error;
  logic [FLAT_W-1:0]    result_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STRIDES_W-1:0] cfg_data = '0;

  logic [DIMS_W-1:0]    a_dims_q, b_dims_q;
  logic [STRIDES_W-1:0] a_str_out_q, a_str_in_q, b_str_out_q, b_str_in_q;

  addr_result_t pending_offsets[$];
  int  errors = 0;
  int  cycles = 0;
  int  recv_stall_pct = 0;

  broadcast_operand_address_gen DUT (
    .clk, .rst, .in_valid, .in_stall, .flat_index, .out_valid, .out_stall,
    .offset_a, .offset_b, .in_range, .shape_error, .result_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] dim_of(logic [DIMS_W-1:0] r, int d);
    return 64'((r >> ((RANK - 1 - d) * DBITS)) & ((1 << DBITS) - 1));
  endfunction

  function automatic logic [63:0] stride_of(logic [63:0] o, logic [63:0] i, int d);
    case (d)
      0: return {32'b0, o[63:32]};
      1: return {32'b0, o[31:0]};
      2: return {32'b0, i[63:32]};
      default: return {32'b0, i[31:0]};
    endcase
  endfunction

  function automatic addr_result_t predict_offsets(logic [FLAT_W-1:0] idx);
    addr_result_t r;
    logic [63:0] as[RANK], bs[RANK], rs[RANK];
    logic [63:0] count, t, c, oa, ob;
    bit err, big;
    count = 1; err = 0; big = 0; oa = 0; ob = 0;
    for (int d = 0; d < RANK; d++) begin
      as[d] = dim_of(a_dims_q, d);
      bs[d] = dim_of(b_dims_q, d);
      if (as[d] == 0 || bs[d] == 0) err = 1;
      if (as[d] != bs[d] && as[d] != 1 && bs[d] != 1) err = 1;
      rs[d] = as[d] > bs[d] ? as[d] : bs[d];
      count = count * rs[d];
      if (count > 64'hFFFF_FFFF) begin
        count = 64'hFFFF_FFFF;
        big = 1;
      end
    end
    r = '0;
    if (err) begin
      r.serr = 1'b1;
      return r;
    end
    r.inr = big || (64'(idx) < count);
    if (r.inr) begin
      t = 64'(idx);
      for (int d = RANK - 1; d >= 0; d--) begin
        c = t % rs[d];
        t = t / rs[d];
        if (as[d] != 1) oa += stride_of(a_str_out_q, a_str_in_q, d) * c;
        if (bs[d] != 1) ob += stride_of(b_str_out_q, b_str_in_q, d) * c;
      end
    end
    r.ofs_a = oa[OFS_W-1:0];
    r.ofs_b = ob[OFS_W-1:0];
    r.cnt   = count[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("broadcast_operand_address_gen verification failed");
      $finish;
    end
    if (!rst) out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && out_valid && !out_stall) begin
      addr_result_t want;
      if (pending_offsets.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        want = pending_offsets.pop_front();
        if (offset_a !== want.ofs_a) begin
          $error("offset_a exp %0h got %0h", want.ofs_a, offset_a); errors++;
        end
        if (offset_b !== want.ofs_b) begin
          $error("offset_b exp %0h got %0h", want.ofs_b, offset_b); errors++;
        end
        if (in_range !== want.inr) begin
          $error("in_range exp %0b got %0b", want.inr, in_range); errors++;
        end
        if (shape_error !== want.serr) begin
          $error("shape_error exp %0b got %0b", want.serr, shape_error); errors++;
        end
        if (result_count !== want.cnt) begin
          $error("result_count exp %0h got %0h", want.cnt, result_count); errors++;
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [STRIDES_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_A_DIMS:          a_dims_q    = val[31:0];
      CFG_B_DIMS:          b_dims_q    = val[31:0];
      CFG_A_STRIDES_OUTER: a_str_out_q = val;
      CFG_A_STRIDES_INNER: a_str_in_q  = val;
      CFG_B_STRIDES_OUTER: b_str_out_q = val;
      default:             b_str_in_q  = val;
    endcase
  endtask

  task automatic drain();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // push one flat index; the expectation is taken when it is accepted
  task automatic send_index(logic [FLAT_W-1:0] idx, int gap_pct, bit known,
                            addr_result_t res);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    flat_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_offsets.insert(pending_offsets.size(), known ? res : predict_offsets(idx));
  endtask

  task automatic set_shape(logic [31:0] ad, logic [31:0] bd, bit rnd_strides);
    drain();
    write_reg(CFG_A_DIMS, {32'b0, ad});
    write_reg(CFG_B_DIMS, {32'b0, bd});
    if (rnd_strides) begin
      write_reg(CFG_A_STRIDES_OUTER, {$urandom, $urandom});
      write_reg(CFG_A_STRIDES_INNER, {$urandom, $urandom});
      write_reg(CFG_B_STRIDES_OUTER, {$urandom, $urandom});
      write_reg(CFG_B_STRIDES_INNER, {$urandom, $urandom});
    end
  endtask

  function automatic logic [31:0] rand_dims(int mode);
    logic [31:0] v;
    for (int d = 0; d < 4; d++)
      case (mode)
        0: v[d*8 +: 8] = ($urandom_range(3) == 0) ? 8'd1 : 8'($urandom_range(1, 9));
        1: v[d*8 +: 8] = 8'($urandom_range(200, 255));
        default: v[d*8 +: 8] = 8'($urandom);
      endcase
    return v;
  endfunction

  initial begin
    stim_row_t rows[$];
    addr_result_t none, r;
    logic [31:0] ad, bd, cnt;
    int gap_pct, mode;

    a_dims_q = DIMS_RESET; b_dims_q = DIMS_RESET;
    a_str_out_q = '0; a_str_in_q = '0; b_str_out_q = '0; b_str_in_q = '0;
    none = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: one element, zero strides
    r = '0; r.inr = 1; r.cnt = 1;
    rows.insert(rows.size(), stim_row_t'{32'd0, 1'b1, r});
    r.inr = 0;
    rows.insert(rows.size(), stim_row_t'{32'd1, 1'b1, r});
    rows.insert(rows.size(), stim_row_t'{32'hFFFF_FFFF, 1'b1, r});
    foreach (rows[i]) send_index(rows[i].idx, 0, rows[i].known, rows[i].res);
    rows.delete();

    // broadcast both ways with all-ones A strides and B strides 7, 5, 3, 1
    set_shape(32'h0201_0403, 32'h0103_0101, 0);
    write_reg(CFG_A_STRIDES_OUTER, '1);
    write_reg(CFG_A_STRIDES_INNER, '1);
    write_reg(CFG_B_STRIDES_OUTER, {32'd7, 32'd5});
    write_reg(CFG_B_STRIDES_INNER, {32'd3, 32'd1});
    for (int i = 0; i < 8; i++) send_index(32'(i * 7), 0, 0, none);
    send_index(32'd71, 0, 0, none);
    send_index(32'd72, 0, 0, none);

    // largest shape: 255 in every dimension
    set_shape(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_index(32'hFFFF_FFFF, 0, 0, none);
    send_index(32'h8000_0000, 0, 0, none);
    send_index(32'h0, 0, 0, none);

    // shape errors: mismatched sizes, then a zero size in A and one in B
    r = '0; r.serr = 1;
    set_shape(32'h0201_0101, 32'h0301_0101, 0);
    send_index(32'd0, 0, 1, r);
    set_shape(32'h0100_0101, 32'h0101_0101, 0);
    send_index(32'd5, 0, 1, r);
    set_shape(32'h0101_0101, 32'h0101_0001, 0);
    send_index(32'hFFFF_FFFF, 0, 1, r);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct        = (phase == 0) ? 30 : (phase == 1) ? 53 : 0;
      recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 30 : 0;
      for (int s = 0; s < 10; s++) begin
        mode = (s == 9) ? 2 : (s == 8) ? 1 : 0;
        ad = rand_dims(mode);
        bd = ($urandom_range(3) == 0) ? rand_dims(mode) : ad;
        for (int d = 0; d < 4; d++)
          if ($urandom_range(2) == 0) begin
            if ($urandom_range(1)) ad[d*8 +: 8] = 8'd1;
            else bd[d*8 +: 8] = 8'd1;
          end
        set_shape(ad, bd, 1);
        r   = predict_offsets(0);
        cnt = r.cnt;
        for (int k = 0; k < 15; k++) begin
          if (k == 7) begin
            in_valid <= 1'b0;
            while (pending_offsets.size() != 0) @(posedge clk);
          end
          if ($urandom_range(9) == 0 || cnt == 0) send_index($urandom, gap_pct, 0, none);
          else send_index($urandom_range(cnt > 0 ? cnt - 1 : 0) + $urandom_range(1),
                          gap_pct, 0, none);
        end
      end
    end

    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("broadcast_operand_address_gen verification clean");
    end else begin
      $display("broadcast_operand_address_gen verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
